// ===== design/cdlf_pkg.sv =====
package cdlf_pkg;

    // Word field widths.
    localparam int DATA_W      = 16;
    localparam int ACC_W       = 40;
    localparam int PROD_W      = 2 * DATA_W;
    localparam int TAP_IDX_W   = 5;
    localparam int CFG_W       = 6;

    // Configuration port.
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;

    localparam logic REG_TAP_COUNT    = 1'b0;
    localparam logic REG_DELAY_OFFSET = 1'b1;

    localparam logic [CFG_W-1:0] TAP_COUNT_RST    = CFG_W'(1);
    localparam logic [CFG_W-1:0] DELAY_OFFSET_RST = '0;

    // Input word function codes.
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_PUSH = 1'b1;

    // Default sizes.
    localparam int DEF_RING_DEPTH = 64;
    localparam int DEF_MAX_TAPS   = 32;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ALIGN,
        ST_ISSUE,
        ST_DRAIN,
        ST_HOLD
    } cdlf_state_t;

    // Sequencer to datapath.
    typedef struct packed {
        logic clr;
        logic ring_we;
        logic coef_we;
        logic issue;
        logic acc_clr;
        logic out_load;
    } cdlf_ctrl_t;

    // Datapath to sequencer.
    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } cdlf_stat_t;

endpackage

// ===== design/cdlf_if.sv =====
interface cdlf_in_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  func;
    logic signed [cdlf_pkg::DATA_W-1:0]    sample_re;
    logic signed [cdlf_pkg::DATA_W-1:0]    sample_im;
    logic        [cdlf_pkg::TAP_IDX_W-1:0] tap_index;
    logic signed [cdlf_pkg::DATA_W-1:0]    coef_re;
    logic signed [cdlf_pkg::DATA_W-1:0]    coef_im;

    modport source (
        output valid, func, sample_re, sample_im, tap_index, coef_re, coef_im,
        input  ready
    );

    modport sink (
        input  valid, func, sample_re, sample_im, tap_index, coef_re, coef_im,
        output ready
    );
endinterface

interface cdlf_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [cdlf_pkg::ACC_W-1:0]  acc_re;
    logic signed [cdlf_pkg::ACC_W-1:0]  acc_im;

    modport source (
        output valid, acc_re, acc_im,
        input  ready
    );

    modport sink (
        input  valid, acc_re, acc_im,
        output ready
    );
endinterface

// ===== design/complex_delay_line_fir_mac.sv =====
// Channel   Direction  Handshake      Word contents
// din       in         valid/ready    func, sample_re, sample_im, tap_index, coef_re, coef_im
// dout      out        valid/ready    acc_re, acc_im
// APB       in         psel/penable   tap_count at 0x0, delay_offset at 0x4
//
// A load word is taken and written while the block is idle. A sample word holds the block
// through accept, alignment, one tap per cycle on the I/Q multiply-accumulate for each of
// T = min(tap_count, MAX_TAPS) taps, the drain and the hand-off; with T zero the taps are
// skipped. Alignment subtracts RING_DEPTH from newest + delay_offset until it lies below the
// ring depth, at most once at the default sizes. After reset a clearing pass zeroes both
// memories, with din not ready. A result still waiting on dout stalls only the next hand-off.

module complex_delay_line_fir_mac #(
    parameter int RING_DEPTH = cdlf_pkg::DEF_RING_DEPTH,
    parameter int MAX_TAPS   = cdlf_pkg::DEF_MAX_TAPS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    cdlf_in_if.sink                           din,
    cdlf_out_if.source                        dout,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [cdlf_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [cdlf_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [cdlf_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    localparam int RW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

    logic [cdlf_pkg::CFG_W-1:0] tap_count;
    logic [cdlf_pkg::CFG_W-1:0] delay_offset;

    // Control from the sequencer and status back from the datapath.
    cdlf_pkg::cdlf_ctrl_t ctrl;
    cdlf_pkg::cdlf_stat_t stat;

    logic [RW-1:0] ring_waddr;
    logic [RW-1:0] ring_raddr;
    logic [CW-1:0] coef_waddr;
    logic [CW-1:0] coef_raddr;

    // Write the two configuration registers only while idle; the block does not enforce it.
    cdlf_apb_regs u_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .tap_count    (tap_count),
        .delay_offset (delay_offset)
    );

    // The sequencer owns the ring write pointer, the tap position walk and the
    // clearing pass, and steps the shared multiply-accumulate once per tap.
    cdlf_seq #(
        .RING_DEPTH (RING_DEPTH),
        .MAX_TAPS   (MAX_TAPS)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (din.valid),
        .in_ready     (din.ready),
        .in_func      (din.func),
        .in_tap_index (din.tap_index),
        .tap_count    (tap_count),
        .delay_offset (delay_offset),
        .stat         (stat),
        .ctrl         (ctrl),
        .ring_waddr   (ring_waddr),
        .ring_raddr   (ring_raddr),
        .coef_waddr   (coef_waddr),
        .coef_raddr   (coef_raddr)
    );

    // The datapath holds the sample ring, the coefficient table, the two 16 by 16
    // multipliers, the 40-bit accumulators and the output register.
    cdlf_mac #(
        .RING_DEPTH (RING_DEPTH),
        .MAX_TAPS   (MAX_TAPS)
    ) u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .stat       (stat),
        .ring_waddr (ring_waddr),
        .ring_raddr (ring_raddr),
        .coef_waddr (coef_waddr),
        .coef_raddr (coef_raddr),
        .sample_re  (din.sample_re),
        .sample_im  (din.sample_im),
        .coef_re    (din.coef_re),
        .coef_im    (din.coef_im),
        .out_valid  (dout.valid),
        .out_ready  (dout.ready),
        .acc_re     (dout.acc_re),
        .acc_im     (dout.acc_im)
    );

endmodule

// ===== design/cdlf_apb_regs.sv =====
module cdlf_apb_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [cdlf_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [cdlf_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [cdlf_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output logic [cdlf_pkg::CFG_W-1:0]        tap_count,
    output logic [cdlf_pkg::CFG_W-1:0]        delay_offset
);

    logic [cdlf_pkg::CFG_W-1:0] tap_count_reg;
    logic [cdlf_pkg::CFG_W-1:0] delay_offset_reg;
    logic                       wr_en;
    logic                       reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    // Registers sit on 4-byte boundaries; the low address bits are ignored.
    assign reg_sel = paddr[cdlf_pkg::APB_ADDR_W-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg    <= cdlf_pkg::TAP_COUNT_RST;
            delay_offset_reg <= cdlf_pkg::DELAY_OFFSET_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                cdlf_pkg::REG_TAP_COUNT:
                begin
                    tap_count_reg <= pwdata[cdlf_pkg::CFG_W-1:0];
                end
                cdlf_pkg::REG_DELAY_OFFSET:
                begin
                    delay_offset_reg <= pwdata[cdlf_pkg::CFG_W-1:0];
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            cdlf_pkg::REG_TAP_COUNT:
            begin
                prdata = cdlf_pkg::APB_DATA_W'(tap_count_reg);
            end
            cdlf_pkg::REG_DELAY_OFFSET:
            begin
                prdata = cdlf_pkg::APB_DATA_W'(delay_offset_reg);
            end
        endcase
    end

    assign tap_count    = tap_count_reg;
    assign delay_offset = delay_offset_reg;

endmodule

// ===== design/cdlf_seq.sv =====
module cdlf_seq #(
    parameter int RING_DEPTH = cdlf_pkg::DEF_RING_DEPTH,
    parameter int MAX_TAPS   = cdlf_pkg::DEF_MAX_TAPS,
    localparam int RW        = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1,
    localparam int CW        = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             in_func,
    input  logic [cdlf_pkg::TAP_IDX_W-1:0]   in_tap_index,
    input  logic [cdlf_pkg::CFG_W-1:0]       tap_count,
    input  logic [cdlf_pkg::CFG_W-1:0]       delay_offset,
    input  cdlf_pkg::cdlf_stat_t             stat,
    output cdlf_pkg::cdlf_ctrl_t             ctrl,
    output logic [RW-1:0]                    ring_waddr,
    output logic [RW-1:0]                    ring_raddr,
    output logic [CW-1:0]                    coef_waddr,
    output logic [CW-1:0]                    coef_raddr
);

    localparam int TCW   = $clog2(MAX_TAPS + 1);
    localparam int TW    = (TCW > cdlf_pkg::CFG_W) ? TCW : cdlf_pkg::CFG_W;
    localparam int SW    = (TCW > cdlf_pkg::TAP_IDX_W) ? TCW : cdlf_pkg::TAP_IDX_W;
    localparam int PW    = $clog2(RING_DEPTH + 64);
    localparam int CLR_N = (RING_DEPTH > MAX_TAPS) ? RING_DEPTH : MAX_TAPS;
    localparam int CLRW  = $clog2(CLR_N + 1);

    localparam logic [PW-1:0]   DEPTH_P   = PW'(RING_DEPTH);
    localparam logic [PW-1:0]   LAST_POS  = PW'(RING_DEPTH - 1);
    localparam logic [RW-1:0]   LAST_PTR  = RW'(RING_DEPTH - 1);
    localparam logic [CLRW-1:0] CLR_LAST  = CLRW'(CLR_N - 1);

    cdlf_pkg::cdlf_state_t state_reg, state_next;

    logic [CLRW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [RW-1:0]   wr_ptr_reg,  wr_ptr_next;
    logic [PW-1:0]   pos_reg,     pos_next;
    logic [TCW-1:0]  taps_reg,    taps_next;
    logic [TCW-1:0]  tap_i_reg,   tap_i_next;

    logic            accept;
    logic            push;
    logic            slot_ok;
    logic [TW-1:0]   taps_sel;
    logic            pos_wraps;

    assign accept    = in_valid & in_ready;
    assign push      = accept & (in_func == cdlf_pkg::FUNC_PUSH);
    assign slot_ok   = SW'(in_tap_index) < SW'(MAX_TAPS);
    assign taps_sel  = (TW'(tap_count) > TW'(MAX_TAPS)) ? TW'(MAX_TAPS) : TW'(tap_count);
    assign pos_wraps = pos_reg >= DEPTH_P;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= cdlf_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
            wr_ptr_reg  <= '0;
            pos_reg     <= '0;
            taps_reg    <= '0;
            tap_i_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            wr_ptr_reg  <= wr_ptr_next;
            pos_reg     <= pos_next;
            taps_reg    <= taps_next;
            tap_i_reg   <= tap_i_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cdlf_pkg::ST_CLEAR:
            begin
                if (clr_cnt_reg == CLR_LAST)
                begin
                    state_next = cdlf_pkg::ST_IDLE;
                end
            end
            cdlf_pkg::ST_IDLE:
            begin
                if (push)
                begin
                    state_next = cdlf_pkg::ST_ALIGN;
                end
            end
            cdlf_pkg::ST_ALIGN:
            begin
                if (!pos_wraps)
                begin
                    state_next = (taps_reg == '0) ? cdlf_pkg::ST_DRAIN : cdlf_pkg::ST_ISSUE;
                end
            end
            cdlf_pkg::ST_ISSUE:
            begin
                if ((tap_i_reg + 1'b1) == taps_reg)
                begin
                    state_next = cdlf_pkg::ST_DRAIN;
                end
            end
            cdlf_pkg::ST_DRAIN:
            begin
                if (!stat.pipe_busy)
                begin
                    state_next = cdlf_pkg::ST_HOLD;
                end
            end
            cdlf_pkg::ST_HOLD:
            begin
                if (stat.out_free)
                begin
                    state_next = cdlf_pkg::ST_IDLE;
                end
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        ctrl       = '0;
        in_ready   = 1'b0;
        ring_waddr = wr_ptr_reg;
        coef_waddr = CW'(in_tap_index);
        ring_raddr = pos_reg[RW-1:0];
        coef_raddr = tap_i_reg[CW-1:0];
        unique case (state_reg)
            cdlf_pkg::ST_CLEAR:
            begin
                ctrl.clr     = 1'b1;
                ctrl.ring_we = clr_cnt_reg < CLRW'(RING_DEPTH);
                ctrl.coef_we = clr_cnt_reg < CLRW'(MAX_TAPS);
                ring_waddr   = clr_cnt_reg[RW-1:0];
                coef_waddr   = clr_cnt_reg[CW-1:0];
            end
            cdlf_pkg::ST_IDLE:
            begin
                in_ready     = 1'b1;
                ctrl.ring_we = push;
                ctrl.acc_clr = push;
                ctrl.coef_we = accept & (in_func == cdlf_pkg::FUNC_LOAD) & slot_ok;
            end
            cdlf_pkg::ST_ALIGN:
            begin
                ctrl = '0;
            end
            cdlf_pkg::ST_ISSUE:
            begin
                ctrl.issue = 1'b1;
            end
            cdlf_pkg::ST_DRAIN:
            begin
                ctrl = '0;
            end
            cdlf_pkg::ST_HOLD:
            begin
                ctrl.out_load = stat.out_free;
            end
        endcase
    end

    // Pointers and counters.
    always_comb
    begin
        clr_cnt_next = clr_cnt_reg;
        wr_ptr_next  = wr_ptr_reg;
        pos_next     = pos_reg;
        taps_next    = taps_reg;
        tap_i_next   = tap_i_reg;
        unique case (state_reg)
            cdlf_pkg::ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            cdlf_pkg::ST_IDLE:
            begin
                if (push)
                begin
                    // The write pointer walks downward, so older samples sit higher.
                    wr_ptr_next = (wr_ptr_reg == '0) ? LAST_PTR : wr_ptr_reg - 1'b1;
                    pos_next    = PW'(wr_ptr_reg) + PW'(delay_offset);
                    taps_next   = taps_sel[TCW-1:0];
                    tap_i_next  = '0;
                end
            end
            cdlf_pkg::ST_ALIGN:
            begin
                // Bring the first tap position below the ring depth.
                if (pos_wraps)
                begin
                    pos_next = pos_reg - DEPTH_P;
                end
            end
            cdlf_pkg::ST_ISSUE:
            begin
                pos_next   = (pos_reg == LAST_POS) ? '0 : pos_reg + 1'b1;
                tap_i_next = tap_i_reg + 1'b1;
            end
            cdlf_pkg::ST_DRAIN:
            begin
                tap_i_next = tap_i_reg;
            end
            cdlf_pkg::ST_HOLD:
            begin
                tap_i_next = tap_i_reg;
            end
        endcase
    end

    a_issue_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cdlf_pkg::ST_ISSUE) |-> (tap_i_reg < taps_reg) && (pos_reg < DEPTH_P))
        else $error("tap issued outside the tap count or the ring");

    a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != cdlf_pkg::ST_CLEAR) |=> (state_reg != cdlf_pkg::ST_CLEAR))
        else $error("clearing pass restarted after reset");

    a_push_aligns: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> (state_reg == cdlf_pkg::ST_ALIGN) && (taps_reg <= TCW'(MAX_TAPS)))
        else $error("sample word did not start a filter pass");

endmodule

// ===== design/cdlf_mac.sv =====
module cdlf_mac #(
    parameter int RING_DEPTH = cdlf_pkg::DEF_RING_DEPTH,
    parameter int MAX_TAPS   = cdlf_pkg::DEF_MAX_TAPS,
    localparam int RW        = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1,
    localparam int CW        = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  cdlf_pkg::cdlf_ctrl_t                    ctrl,
    output cdlf_pkg::cdlf_stat_t                    stat,
    input  logic [RW-1:0]                           ring_waddr,
    input  logic [RW-1:0]                           ring_raddr,
    input  logic [CW-1:0]                           coef_waddr,
    input  logic [CW-1:0]                           coef_raddr,
    input  logic signed [cdlf_pkg::DATA_W-1:0]      sample_re,
    input  logic signed [cdlf_pkg::DATA_W-1:0]      sample_im,
    input  logic signed [cdlf_pkg::DATA_W-1:0]      coef_re,
    input  logic signed [cdlf_pkg::DATA_W-1:0]      coef_im,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [cdlf_pkg::ACC_W-1:0]       acc_re,
    output logic signed [cdlf_pkg::ACC_W-1:0]       acc_im
);

    localparam int PAIR_W = 2 * cdlf_pkg::DATA_W;
    localparam int DW     = cdlf_pkg::DATA_W;

    // Entries hold {re, im}.
    logic [PAIR_W-1:0] ring_mem [RING_DEPTH];
    logic [PAIR_W-1:0] coef_mem [MAX_TAPS];

    logic [PAIR_W-1:0] ring_rd_reg;
    logic [PAIR_W-1:0] coef_rd_reg;
    logic              s1_valid_reg;
    logic              s2_valid_reg;

    logic signed [cdlf_pkg::PROD_W-1:0] prod_re_reg;
    logic signed [cdlf_pkg::PROD_W-1:0] prod_im_reg;
    logic signed [cdlf_pkg::PROD_W-1:0] prod_re_next;
    logic signed [cdlf_pkg::PROD_W-1:0] prod_im_next;
    logic signed [DW-1:0]               smp_re;
    logic signed [DW-1:0]               smp_im;
    logic signed [DW-1:0]               cof_re;
    logic signed [DW-1:0]               cof_im;

    logic signed [cdlf_pkg::ACC_W-1:0]  sum_re_reg;
    logic signed [cdlf_pkg::ACC_W-1:0]  sum_im_reg;
    logic signed [cdlf_pkg::ACC_W-1:0]  out_re_reg;
    logic signed [cdlf_pkg::ACC_W-1:0]  out_im_reg;
    logic                               out_valid_reg;
    logic                               out_valid_next;

    always_ff @(posedge clk)
    begin
        if (ctrl.ring_we)
        begin
            ring_mem[ring_waddr] <= ctrl.clr ? '0 : {sample_re, sample_im};
        end
        if (ctrl.coef_we)
        begin
            coef_mem[coef_waddr] <= ctrl.clr ? '0 : {coef_re, coef_im};
        end
        if (ctrl.issue)
        begin
            ring_rd_reg <= ring_mem[ring_raddr];
            coef_rd_reg <= coef_mem[coef_raddr];
        end
    end

    assign smp_re = ring_rd_reg[PAIR_W-1:DW];
    assign smp_im = ring_rd_reg[DW-1:0];
    assign cof_re = coef_rd_reg[PAIR_W-1:DW];
    assign cof_im = coef_rd_reg[DW-1:0];

    assign prod_re_next = smp_re * cof_re;
    assign prod_im_next = smp_im * cof_im;

    // Product stage, then the accumulate stage; both rails run side by side.
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            prod_re_reg <= prod_re_next;
            prod_im_reg <= prod_im_next;
        end
        if (ctrl.acc_clr)
        begin
            sum_re_reg <= '0;
            sum_im_reg <= '0;
        end
        else if (s2_valid_reg)
        begin
            sum_re_reg <= sum_re_reg + cdlf_pkg::ACC_W'(prod_re_reg);
            sum_im_reg <= sum_im_reg + cdlf_pkg::ACC_W'(prod_im_reg);
        end
        if (ctrl.out_load)
        begin
            out_re_reg <= sum_re_reg;
            out_im_reg <= sum_im_reg;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctrl.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= ctrl.issue;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= out_valid_next;
        end
    end

    assign stat.pipe_busy = s1_valid_reg | s2_valid_reg;
    assign stat.out_free  = ~out_valid_reg | out_ready;

    assign out_valid = out_valid_reg;
    assign acc_re    = out_re_reg;
    assign acc_im    = out_im_reg;

    a_pipe_order: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> $past(s1_valid_reg))
        else $error("product stage valid without a preceding read");

    a_load_drained: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.out_load |-> !stat.pipe_busy && !ctrl.issue)
        else $error("result taken while taps were still in flight");

endmodule

// ===== tb/tb_complex_delay_line_fir_mac.sv =====
module tb_complex_delay_line_fir_mac;

    // Sizes the block is built with here; the predictor mirrors them.
    localparam int RING_DEPTH = cdlf_pkg::DEF_RING_DEPTH;
    localparam int MAX_TAPS   = cdlf_pkg::DEF_MAX_TAPS;

    localparam int DATA_W     = cdlf_pkg::DATA_W;
    localparam int ACC_W      = cdlf_pkg::ACC_W;
    localparam int TAP_IDX_W  = cdlf_pkg::TAP_IDX_W;
    localparam int CFG_W      = cdlf_pkg::CFG_W;
    localparam int APB_ADDR_W = cdlf_pkg::APB_ADDR_W;
    localparam int APB_DATA_W = cdlf_pkg::APB_DATA_W;

    // Random part: ten filter settings, about a hundred words each.
    localparam int NUM_PHASES      = 10;
    localparam int WORDS_PER_PHASE = 100;

    // A sample word holds the block through its taps, the drain and the hand-off, and both sides
    // can add idle holes, as can the clearing pass after reset. The limit below is several times
    // the worst quiet stretch of a correct run.
    localparam int SETTLE_CYCLES = 60;
    localparam int STALL_LIMIT   = 5000;

    // One input word as the testbench keeps it. drain_first holds the word back until
    // every sum already owed has come out.
    typedef struct {
        logic                     func;
        logic signed [DATA_W-1:0] sre;
        logic signed [DATA_W-1:0] sim;
        logic [TAP_IDX_W-1:0]     tidx;
        logic signed [DATA_W-1:0] cre;
        logic signed [DATA_W-1:0] cim;
        bit                       drain_first;
    } fir_word_t;

    // One pair of accumulated sums, I rail and Q rail.
    typedef struct {
        logic signed [ACC_W-1:0] re;
        logic signed [ACC_W-1:0] im;
    } fir_sum_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    cdlf_in_if  din_if ();
    cdlf_out_if dout_if ();

    complex_delay_line_fir_mac dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .din     (din_if),
        .dout    (dout_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Words waiting to be sent, and the sums the filter still owes us.
    fir_word_t word_q[$];
    fir_sum_t  fir_sum_q[$];
    int        words_pending = 0;
    fir_word_t word_cur;

    // The predictor's own copy of the delay line, coefficient table and filter settings.
    logic signed [DATA_W-1:0] ring_re [RING_DEPTH];
    logic signed [DATA_W-1:0] ring_im [RING_DEPTH];
    logic signed [DATA_W-1:0] coef_re_tab [MAX_TAPS];
    logic signed [DATA_W-1:0] coef_im_tab [MAX_TAPS];
    int                       ring_wr;
    logic [CFG_W-1:0]         cfg_taps;
    logic [CFG_W-1:0]         cfg_delay;

    int src_gap     = 0;
    int snk_stall   = 0;
    bit quiet_src   = 1'b0;
    bit quiet_snk   = 1'b0;
    int err_count   = 0;
    int idle_cycles = 0;

    // Idle lengths: mostly none, now and then a long hole.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Q1.15 values with a strong lean toward the corners of the range.
    function automatic logic [DATA_W-1:0] pick_q15();
        case ($urandom_range(0, 19))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return DATA_W'($urandom());
        endcase
    endfunction

    // A load word; the sample fields are don't-care and carry noise.
    function automatic fir_word_t mk_load(input int idx, input logic [DATA_W-1:0] cre,
                                          input logic [DATA_W-1:0] cim);
        fir_word_t w;
        w.func        = cdlf_pkg::FUNC_LOAD;
        w.sre         = DATA_W'($urandom());
        w.sim         = DATA_W'($urandom());
        w.tidx        = TAP_IDX_W'(idx);
        w.cre         = cre;
        w.cim         = cim;
        w.drain_first = 1'b0;
        return w;
    endfunction

    // A sample word; the slot and coefficient fields are don't-care and carry noise.
    function automatic fir_word_t mk_push(input logic [DATA_W-1:0] sre,
                                          input logic [DATA_W-1:0] sim);
        fir_word_t w;
        w.func        = cdlf_pkg::FUNC_PUSH;
        w.sre         = sre;
        w.sim         = sim;
        w.tidx        = TAP_IDX_W'($urandom());
        w.cre         = DATA_W'($urandom());
        w.cim         = DATA_W'($urandom());
        w.drain_first = 1'b0;
        return w;
    endfunction

    // Apply one accepted word to the predicted state. A sample word goes in at the write
    // pointer, which then steps down, so older samples sit at higher ring positions. The
    // taps start delay positions back from the newest sample and wrap around the ring.
    // Products are extended to the full 40-bit accumulator before summing.
    function automatic void fir_step(input fir_word_t w);
        fir_sum_t s;
        int       taps;
        int       newest;
        int       pos;
        if (w.func == cdlf_pkg::FUNC_LOAD)
        begin
            if (w.tidx < MAX_TAPS)
            begin
                coef_re_tab[w.tidx] = w.cre;
                coef_im_tab[w.tidx] = w.cim;
            end
            return;
        end
        ring_re[ring_wr] = w.sre;
        ring_im[ring_wr] = w.sim;
        newest  = ring_wr;
        ring_wr = (ring_wr == 0) ? RING_DEPTH - 1 : ring_wr - 1;
        // Tap counts past the table size fall back to the full table.
        taps = (cfg_taps > MAX_TAPS) ? MAX_TAPS : int'(cfg_taps);
        s.re = '0;
        s.im = '0;
        for (int i = 0; i < taps; i++)
        begin
            pos  = (newest + int'(cfg_delay) + i) % RING_DEPTH;
            s.re = s.re + ring_re[pos] * coef_re_tab[i];
            s.im = s.im + ring_im[pos] * coef_im_tab[i];
        end
        fir_sum_q.push_back(s);
    endfunction

    task automatic queue_word(input fir_word_t w);
        word_q.push_back(w);
        words_pending++;
    endtask

    // Wait until every word has been taken and every sum has come out, then give the
    // block time to finish a trailing load word, which produces no sum to wait for.
    task automatic wait_idle();
        while (words_pending > 0 || fir_sum_q.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write: setup cycle, then access cycle held until pready. Upper data bits carry
    // noise, since only the low six bits belong to either register.
    task automatic reg_write(input logic [APB_ADDR_W-1:0] addr, input logic [CFG_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= ($urandom() & ~32'h3F) | APB_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Only called while the filter is idle, so the predictor can switch at once.
    task automatic set_filter(input int taps, input int delay);
        reg_write({cdlf_pkg::REG_TAP_COUNT, 2'b00}, CFG_W'(taps));
        cfg_taps = CFG_W'(taps);
        reg_write({cdlf_pkg::REG_DELAY_OFFSET, 2'b00}, CFG_W'(delay));
        cfg_delay = CFG_W'(delay);
    endtask

    // Word driver. A new word (or an idle cycle) is chosen whenever the channel is free:
    // either nothing was offered or the offered word was just taken. The valid line gets
    // at most one assignment per edge.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            din_if.valid <= 1'b0;
        end
        else
        begin
            if (din_if.valid && din_if.ready)
            begin
                fir_step(word_cur);
                words_pending--;
                src_gap = quiet_src ? 0 : pick_gap();
            end
            if (!din_if.valid || din_if.ready)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    din_if.valid <= 1'b0;
                end
                else if (word_q.size() > 0 &&
                         !(word_q[0].drain_first && fir_sum_q.size() > 0))
                begin
                    word_cur = word_q.pop_front();
                    din_if.valid     <= 1'b1;
                    din_if.func      <= word_cur.func;
                    din_if.sample_re <= word_cur.sre;
                    din_if.sample_im <= word_cur.sim;
                    din_if.tap_index <= word_cur.tidx;
                    din_if.coef_re   <= word_cur.cre;
                    din_if.coef_im   <= word_cur.cim;
                end
                else
                begin
                    din_if.valid <= 1'b0;
                end
            end
        end
    end

    // Result sink: ready drops for random stretches unless this phase runs it flat out.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            dout_if.ready <= 1'b0;
        end
        else if (snk_stall > 0)
        begin
            snk_stall--;
            dout_if.ready <= 1'b0;
        end
        else
        begin
            dout_if.ready <= 1'b1;
            if (!quiet_snk && $urandom_range(0, 3) == 0)
                snk_stall = pick_gap();
        end
    end

    // Result monitor: every sum taken is checked against the oldest one predicted.
    always @(posedge clk)
    begin
        fir_sum_t sum_exp;
        if (rst_n && dout_if.valid && dout_if.ready)
        begin
            if (fir_sum_q.size() == 0)
            begin
                $error("unexpected word on dout: acc_re %0d acc_im %0d",
                       dout_if.acc_re, dout_if.acc_im);
                err_count++;
            end
            else
            begin
                sum_exp = fir_sum_q.pop_front();
                if (dout_if.acc_re !== sum_exp.re)
                begin
                    $error("acc_re mismatch: expected %0d, got %0d",
                           sum_exp.re, dout_if.acc_re);
                    err_count++;
                end
                if (dout_if.acc_im !== sum_exp.im)
                begin
                    $error("acc_im mismatch: expected %0d, got %0d",
                           sum_exp.im, dout_if.acc_im);
                    err_count++;
                end
            end
        end
    end

    // Watchdog: any handshake on either channel or the register port counts as progress.
    always @(posedge clk)
    begin
        if (!rst_n || (din_if.valid && din_if.ready) || (dout_if.valid && dout_if.ready) ||
            (psel && penable && pready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("complex_delay_line_fir_mac verification failed");
                $finish;
            end
        end
    end

    // Per-phase filter settings for the random part, extremes included: tap counts of
    // zero, one, the full table and beyond it, and delays at both ends of the ring.
    int tap_plan   [NUM_PHASES] = '{32, 0, 63, 1, 33, 17, 8, 32, 5, 24};
    int delay_plan [NUM_PHASES] = '{0, 5, 63, 63, 17, 40, 1, 62, 0, 31};

    initial
    begin
        fir_word_t w;

        // Known values on every input before the first edge.
        din_if.valid     = 1'b0;
        din_if.func      = cdlf_pkg::FUNC_LOAD;
        din_if.sample_re = '0;
        din_if.sample_im = '0;
        din_if.tap_index = '0;
        din_if.coef_re   = '0;
        din_if.coef_im   = '0;
        dout_if.ready    = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;

        // Predicted state after reset: everything cleared, one tap, no extra delay.
        for (int i = 0; i < RING_DEPTH; i++)
        begin
            ring_re[i] = '0;
            ring_im[i] = '0;
        end
        for (int i = 0; i < MAX_TAPS; i++)
        begin
            coef_re_tab[i] = '0;
            coef_im_tab[i] = '0;
        end
        ring_wr   = 0;
        cfg_taps  = cdlf_pkg::TAP_COUNT_RST;
        cfg_delay = cdlf_pkg::DELAY_OFFSET_RST;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset settings. A sample against the cleared table must
        // give zero; then the full-scale corners of a single tap, including the most
        // negative value squared, plus loads to both ends of the table.
        queue_word(mk_push(16'h7FFF, 16'h8000));
        queue_word(mk_load(0, 16'h7FFF, 16'h8000));
        queue_word(mk_push(16'h7FFF, 16'h8000));
        queue_word(mk_push(16'h8000, 16'h7FFF));
        queue_word(mk_push(16'h8000, 16'h8000));
        queue_word(mk_push(16'h0000, 16'hFFFF));
        queue_word(mk_load(31, 16'h8000, 16'h7FFF));
        queue_word(mk_load(0, 16'h8000, 16'h8000));
        // This one waits for the filter to empty first.
        w = mk_push(16'h8000, 16'h8000);
        w.drain_first = 1'b1;
        queue_word(w);
        queue_word(mk_load(1, 16'h4000, 16'hC000));
        wait_idle();

        // Tap count above the table size saturates, and the largest delay wraps all the
        // way round so the first tap reads the oldest sample in the ring.
        set_filter(63, 63);
        queue_word(mk_push(16'h1234, 16'hEDCB));
        queue_word(mk_push(16'h7FFF, 16'h7FFF));
        queue_word(mk_push(16'h8000, 16'h0001));
        queue_word(mk_load(30, 16'h7FFF, 16'h8000));
        queue_word(mk_push(16'hFFFF, 16'h8000));
        wait_idle();

        // A tap count of zero yields zero on both rails whatever the table holds.
        set_filter(0, 0);
        queue_word(mk_push(16'h7FFF, 16'h8000));
        queue_word(mk_push(16'h8000, 16'h7FFF));
        wait_idle();

        // Random part. Mostly sample words, one in five a coefficient load, and now and
        // then a word that waits for the filter to drain.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            quiet_src = (p == 3);
            quiet_snk = (p == 3) || (p == 6);
            set_filter(tap_plan[p], delay_plan[p]);
            if (p == 7)
            begin
                // Every slot and forty samples at the most negative value, so most taps see the largest
                // product; the sum comes near the largest the accumulator can see at these sizes.
                for (int k = 0; k < MAX_TAPS; k++)
                    queue_word(mk_load(k, 16'h8000, 16'h8000));
                for (int k = 0; k < 40; k++)
                    queue_word(mk_push(16'h8000, 16'h8000));
            end
            for (int k = 0; k < WORDS_PER_PHASE; k++)
            begin
                if ($urandom_range(0, 4) == 0)
                    w = mk_load($urandom_range(0, MAX_TAPS - 1), pick_q15(), pick_q15());
                else
                    w = mk_push(pick_q15(), pick_q15());
                w.drain_first = ($urandom_range(0, 49) == 0);
                queue_word(w);
            end
            wait_idle();
        end

        if (err_count == 0)
            $display("complex_delay_line_fir_mac verification clean");
        else
            $display("complex_delay_line_fir_mac verification failed");
        $finish;
    end

endmodule
